// ===== sv/dq_pkg.sv =====
`timescale 1ns / 1ps
package dq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_ADD_FRONT    = 3'd0,
    KIND_ADD_BACK     = 3'd1,
    KIND_REMOVE_FRONT = 3'd2,
    KIND_REMOVE_BACK  = 3'd3,
    KIND_PEEK_FRONT   = 3'd4,
    KIND_PEEK_BACK    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN,
    OP_WRITE_BACK,
    OP_CLEAR_BACK
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [DATA_WIDTH-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] data;
  } slot_t;

endpackage

// ===== sv/dq_cell.sv =====
`timescale 1ns / 1ps
module dq_cell
  import dq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  slot_t                 left,
  input  slot_t                 right,
  output slot_t                 slot,
  output logic [DATA_WIDTH-1:0] back_data
);

  logic                  valid;
  logic                  valid_next;
  logic [DATA_WIDTH-1:0] data;
  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    valid_next = valid;
    data_next  = data;
    case (cmd.op)
      OP_SHIFT_UP: begin
        valid_next = left.valid;
        data_next  = left.data;
      end
      OP_SHIFT_DOWN: begin
        valid_next = right.valid;
        data_next  = right.data;
      end
      OP_WRITE_BACK: begin
        if (!valid && left.valid) begin
          valid_next = 1'b1;
          data_next  = cmd.value;
        end
      end
      OP_CLEAR_BACK: begin
        if (valid && !right.valid) begin
          valid_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign slot.valid = valid;
  assign slot.data  = data;
  // this cell holds the back entry
  assign back_data  = (valid && !right.valid) ? data : '0;

endmodule

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Bounded deque of DEPTH entries held in a row of cells, front always in cell 0 and
// entries packed toward higher cells. Adds at the front shift the row up, removes at
// the front shift it down; back adds and removes touch only the cell at the boundary
// of the occupied run. One beat is taken per cycle unless the output stalls, and each
// gives exactly one result beat in the following cycle from an output register, so a
// new beat is accepted while the previous result is taken. Adds to a full queue are
// dropped with status full; removes and peeks on an empty queue return status empty.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] value
  input  logic [2:0]  s_tuser,  // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] result_value, [38:32] entry_count, [39] is_empty
  output logic [1:0]  m_tuser   // [1:0] status
);

  slot_t                 slots     [DEPTH];
  slot_t                 left_in   [DEPTH];
  slot_t                 right_in  [DEPTH];
  logic [DATA_WIDTH-1:0] back_part [DEPTH];
  logic [DEPTH-1:0]      valid_vec;

  cell_cmd_t             cmd;
  cell_op_t              op;
  logic                  accept;
  logic                  empty;
  logic                  full;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;
  logic [DATA_WIDTH-1:0] res;
  status_t               st;

  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  logic [VALUE_W-1:0]    result_value;
  status_t               status;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign empty       = !slots[0].valid;
  assign full        = slots[DEPTH-1].valid;
  assign front_value = slots[0].data;

  assign cmd.op    = accept ? op : OP_HOLD;
  assign cmd.value = s_tdata[DATA_WIDTH-1:0];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign left_in[g].valid = 1'b1;
        assign left_in[g].data  = s_tdata[DATA_WIDTH-1:0];
      end else begin : g_mid_l
        assign left_in[g] = slots[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_in[g] = '0;
      end else begin : g_mid_r
        assign right_in[g] = slots[g+1];
      end
      assign valid_vec[g] = slots[g].valid;

      dq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .left      (left_in[g]),
        .right     (right_in[g]),
        .slot      (slots[g]),
        .back_data (back_part[g])
      );
    end
  endgenerate

  // at most one cell drives a nonzero back value
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | back_part[i];
    end
  end

  always_comb begin
    op         = OP_HOLD;
    res        = '0;
    st         = ST_OK;
    count_next = count;
    case (s_tuser)
      KIND_ADD_FRONT, KIND_ADD_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          op         = (s_tuser == KIND_ADD_FRONT) ? OP_SHIFT_UP : OP_WRITE_BACK;
          count_next = count + 1'b1;
        end
      end
      KIND_REMOVE_FRONT, KIND_REMOVE_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (s_tuser == KIND_REMOVE_FRONT) begin
          op         = OP_SHIFT_DOWN;
          res        = front_value;
          count_next = count - 1'b1;
        end else begin
          op         = OP_CLEAR_BACK;
          res        = back_value;
          count_next = count - 1'b1;
        end
      end
      KIND_PEEK_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          res = front_value;
        end
      end
      KIND_PEEK_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          res = back_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      count    <= '0;
    end else begin
      if (accept) begin
        m_tvalid <= 1'b1;
        count    <= count_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_value <= VALUE_W'(res);
      status       <= st;
    end
  end

  assign m_tdata[31:0]  = result_value;
  assign m_tdata[38:32] = count;
  assign m_tdata[39]    = (count == '0);
  assign m_tuser        = status;

`ifndef SYNTHESIS
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("entry count disagrees with occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied cells are not packed toward the front");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_FULL) |-> (int'(count) == DEPTH))
    else $error("full status reported below capacity");

  a_empty_status_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_EMPTY) |-> (count == '0))
    else $error("empty status reported with stored entries");
`endif

endmodule

// ===== sim/deque_checker.sv =====
`timescale 1ns / 1ps
module deque_checker
  import dq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          mismatches,
  output int          outstanding,
  output int          results_checked,
  output int          full_drops,
  output int          empty_errors
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } deque_result_t;

  logic [DATA_WIDTH-1:0]    ring [DEPTH];
  logic [$clog2(DEPTH)-1:0] head;
  logic [$clog2(DEPTH)-1:0] tail;
  logic [COUNT_W-1:0]       fill;
  deque_result_t            pending_results [$];
  int                       bad_cnt;
  int                       seen_cnt;
  int                       full_cnt;
  int                       empty_cnt;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
    full_drops      = 0;
    empty_errors    = 0;
    bad_cnt         = 0;
    seen_cnt        = 0;
    full_cnt        = 0;
    empty_cnt       = 0;
    head            = '0;
    tail            = '0;
    fill            = '0;
  end

  // Apply one operation to the shadow ring and return the result it should give.
  function automatic deque_result_t deque_apply(input logic [2:0] kind,
                                                input logic [31:0] value);
    deque_result_t            r;
    logic [$clog2(DEPTH)-1:0] last;
    r.value  = '0;
    r.status = ST_OK;
    last     = tail - 1'b1;
    case (kind)
      KIND_ADD_FRONT, KIND_ADD_BACK: begin
        if (fill == DEPTH) begin
          r.status = ST_FULL;
        end else if (kind == KIND_ADD_FRONT) begin
          head       = head - 1'b1;
          ring[head] = value[DATA_WIDTH-1:0];
          fill       = fill + 1'b1;
        end else begin
          ring[tail] = value[DATA_WIDTH-1:0];
          tail       = tail + 1'b1;
          fill       = fill + 1'b1;
        end
      end
      KIND_REMOVE_FRONT, KIND_REMOVE_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          case (kind)
            KIND_REMOVE_FRONT: begin
              r.value = VALUE_W'(ring[head]);
              head    = head + 1'b1;
              fill    = fill - 1'b1;
            end
            KIND_REMOVE_BACK: begin
              tail    = last;
              r.value = VALUE_W'(ring[tail]);
              fill    = fill - 1'b1;
            end
            KIND_PEEK_FRONT: r.value = VALUE_W'(ring[head]);
            default:         r.value = VALUE_W'(ring[last]);
          endcase
        end
      end
      default: ;  // unused kinds leave everything as is
    endcase
    r.count = fill;
    r.empty = (fill == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst) begin
      head = '0;
      tail = '0;
      fill = '0;
      pending_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        pending_results.push_back(deque_apply(s_tuser, s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got.value  = m_tdata[31:0];
        got.count  = m_tdata[38:32];
        got.empty  = m_tdata[39];
        got.status = status_t'(m_tuser);
        if (pending_results.size() == 0) begin
          if (bad_cnt < 10) begin
            $display("%0t: result beat with nothing expected:", $time);
            $display("%0t:   value %h status %0d count %0d empty %0b",
                     $time, got.value, got.status, got.count, got.empty);
          end
          bad_cnt++;
        end else begin
          want = pending_results.pop_front();
          seen_cnt++;
          if (want.status == ST_FULL)  full_cnt++;
          if (want.status == ST_EMPTY) empty_cnt++;
          if (got.value !== want.value || got.status !== want.status ||
              got.count !== want.count || got.empty !== want.empty) begin
            if (bad_cnt < 10) begin
              $display("%0t: mismatch: expected value %h status %0d count %0d empty %0b",
                       $time, want.value, want.status, want.count, want.empty);
              $display("%0t:           got      value %h status %0d count %0d empty %0b",
                       $time, got.value, got.status, got.count, got.empty);
            end
            bad_cnt++;
          end
        end
      end
    end
    mismatches      <= bad_cnt;
    outstanding     <= pending_results.size();
    results_checked <= seen_cnt;
    full_drops      <= full_cnt;
    empty_errors    <= empty_cnt;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import dq_pkg::*;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam int MODE_FILL   = 0;
  localparam int MODE_DRAIN  = 1;
  localparam int MODE_MIXED  = 2;
  localparam int BUSY_ITEMS  = 1150;
  localparam int CALM_AFTER  = 1000;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  int mismatches;
  int outstanding;
  int results_checked;
  int full_drops;
  int empty_errors;
  int cycles        = 0;
  int ready_left    = 0;
  int ignored_sent  = 0;
  bit calm          = 1'b0;
  bit sender_stalls = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  double_ended_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  deque_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .full_drops      (full_drops),
    .empty_errors    (empty_errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure: random ready and stall bursts.
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready   <= 1'b1;
      ready_left <= 0;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        m_tready   <= 1'b0;
        ready_left <= $urandom_range(0, 15);
      end else begin
        m_tready   <= 1'b1;
        ready_left <= $urandom_range(1, 24);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  task automatic send_beat(input logic [2:0] kind, input logic [31:0] value);
    if (!calm && sender_stalls && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    if (kind == KIND_UNUSED_LO || kind == KIND_UNUSED_HI) ignored_sent++;
  endtask

  function automatic logic [2:0] pick_kind(input int mode);
    int roll;
    int add_pct;
    roll = $urandom_range(0, 99);
    if (roll < 2) return $urandom_range(0, 1) ? KIND_UNUSED_HI : KIND_UNUSED_LO;
    add_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 15 : 50;
    if ($urandom_range(0, 99) < add_pct) begin
      return $urandom_range(0, 1) ? KIND_ADD_BACK : KIND_ADD_FRONT;
    end
    case ($urandom_range(0, 5))
      0, 1:    return KIND_REMOVE_FRONT;
      2, 3:    return KIND_REMOVE_BACK;
      4:       return KIND_PEEK_FRONT;
      default: return KIND_PEEK_BACK;
    endcase
  endfunction

  initial begin
    int         busy;
    int         round_len;
    int         mode;
    logic [2:0] kind;
    busy = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty deque, ignored kinds, data extremes at both ends
    send_beat(KIND_PEEK_FRONT,   $urandom);
    send_beat(KIND_PEEK_BACK,    $urandom);
    send_beat(KIND_REMOVE_FRONT, $urandom);
    send_beat(KIND_REMOVE_BACK,  $urandom);
    send_beat(KIND_UNUSED_LO,    32'hFFFF_FFFF);
    send_beat(KIND_UNUSED_HI,    32'h0);
    send_beat(KIND_ADD_FRONT,    32'h0);
    send_beat(KIND_PEEK_FRONT,   32'h0);
    send_beat(KIND_PEEK_BACK,    32'h0);
    send_beat(KIND_ADD_BACK,     32'hFFFF_FFFF);
    send_beat(KIND_ADD_FRONT,    32'hAAAA_AAAA);
    send_beat(KIND_ADD_BACK,     32'h5555_5555);
    send_beat(KIND_PEEK_FRONT,   32'hFFFF_FFFF);
    send_beat(KIND_PEEK_BACK,    32'hFFFF_FFFF);
    send_beat(KIND_UNUSED_LO,    32'h1234_5678);
    send_beat(KIND_REMOVE_BACK,  32'hFFFF_FFFF);
    send_beat(KIND_REMOVE_FRONT, 32'hFFFF_FFFF);
    send_beat(KIND_REMOVE_BACK,  32'h0);
    send_beat(KIND_REMOVE_FRONT, 32'h0);
    send_beat(KIND_REMOVE_FRONT, 32'h0);
    send_beat(KIND_PEEK_BACK,    32'h0);

    // fill past full, then a drain-heavy round, then random rounds
    for (int i = 0; i < 90; i++) begin
      send_beat($urandom_range(0, 1) ? KIND_ADD_BACK : KIND_ADD_FRONT, $urandom);
      busy++;
    end
    for (int i = 0; i < 90; i++) begin
      kind = pick_kind(MODE_DRAIN);
      send_beat(kind, $urandom);
      if (kind != KIND_UNUSED_LO && kind != KIND_UNUSED_HI) busy++;
    end
    while (busy < BUSY_ITEMS) begin
      mode          = $urandom_range(MODE_FILL, MODE_MIXED);
      round_len     = $urandom_range(20, 120);
      sender_stalls = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < round_len && busy < BUSY_ITEMS; i++) begin
        if (busy >= CALM_AFTER) calm = 1'b1;
        kind = pick_kind(mode);
        send_beat(kind, $urandom);
        if (kind != KIND_UNUSED_LO && kind != KIND_UNUSED_HI) busy++;
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("deque run: %0d results checked, %0d ignored kinds sent", results_checked,
             ignored_sent);
    $display("%0d adds dropped on full, %0d empty errors, %0d mismatches", full_drops,
             empty_errors, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue.f =====
sv/dq_pkg.sv
sv/dq_cell.sv
sv/double_ended_queue.sv
sim/deque_checker.sv
sim/tb_top.sv
